>>> design/ehc_pkg.sv
// Shared types, widths and elaboration-time constant functions for the exp CORDIC.
package ehc_pkg;

  localparam int unsigned ITERATIONS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 24;
  localparam int unsigned INT_BITS       = 6;
  localparam int unsigned X_W            = 21;
  localparam int unsigned E_W            = 17;
  localparam int unsigned IO_FRAC        = 16;
  localparam int unsigned K_SPAN         = 12;
  localparam int unsigned THR_N          = 11;
  localparam int unsigned HIQ            = 60;

  localparam logic signed [X_W-1:0] X_LOW = -21'sd524288;
  localparam logic [63:0] ONE_HIQ = 64'd1 << HIQ;

  typedef struct packed {
    logic              vld;
    logic              zero;
    logic signed [4:0] k;
  } ctl_t;

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] ln2_hiq();
    logic [63:0] acc;
    acc = '0;
    for (int n = 1; n <= 60; n++) begin
      acc = acc + udiv(ONE_HIQ >> n, 64'(n));
    end
    return acc;
  endfunction

  function automatic logic [63:0] atanh_hiq(input int unsigned s);
    logic [63:0] acc;
    int unsigned e;
    acc = '0;
    for (int m = 0; m < 64; m++) begin
      e = s * (2 * m + 1);
      if (e <= HIQ) begin
        acc = acc + udiv(ONE_HIQ >> e, 64'(2 * m + 1));
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] gain_hiq(input int unsigned s);
    logic [63:0] t;
    logic [63:0] acc;
    logic        done;
    t    = ONE_HIQ;
    acc  = ONE_HIQ;
    done = 1'b0;
    for (int n = 1; n < 64; n++) begin
      if (!done) begin
        t = udiv(t * 64'(2 * n - 1), 64'(2 * n));
        t = (2 * s >= 63) ? 64'd0 : (t >> (2 * s));
        if (t == 64'd0) begin
          done = 1'b1;
        end else begin
          acc = acc + t;
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] mul_hiq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic int unsigned shift_of(input int unsigned i);
    if (i < 4) return i + 1;
    if (i < 14) return i;
    return i - 1;
  endfunction

  function automatic logic [63:0] invk_hiq(input int unsigned iters);
    logic [63:0] acc;
    acc = ONE_HIQ;
    for (int unsigned i = 0; i < 20; i++) begin
      if (i < iters) begin
        acc = mul_hiq(acc, gain_hiq(shift_of(i)));
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] floor_f(input logic [63:0] v, input int unsigned fb);
    return v >> (HIQ - fb);
  endfunction

  function automatic logic [63:0] ceil_f(input logic [63:0] v, input int unsigned fb);
    logic [63:0] m;
    m = (64'd1 << (HIQ - fb)) - 64'd1;
    return (v + m) >> (HIQ - fb);
  endfunction

endpackage

>>> design/exp_hyperbolic_cordic.sv
// Top level: exp(x) for x in [-8, 0] by range reduction and pipelined hyperbolic CORDIC.
//
// Fully pipelined: a new argument is taken on every cycle that start is high, and busy
// never rises. The result strobes on out_valid after the request is taken and has passed
// three range-reduction stages, one stage per rotation and one output stage.
// The result side has no hold-off: out_exp_value is valid only in the out_valid cycle,
// and the receiver cannot stall it.
// Arguments below -8.0 return 0; positive arguments return the result for 0.
module exp_hyperbolic_cordic import ehc_pkg::*; #(
  parameter int unsigned ITERATIONS         = ITERATIONS_DEF,
  parameter int unsigned INTERNAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [X_W-1:0] in_x_value,
  output logic                  out_valid,
  output logic [E_W-1:0]        out_exp_value
);

  localparam int unsigned WD = INTERNAL_FRAC_BITS + INT_BITS;
  localparam int unsigned OSH = INTERNAL_FRAC_BITS - IO_FRAC;
  localparam logic [WD-1:0] INVK = WD'(floor_f(invk_hiq(ITERATIONS), INTERNAL_FRAC_BITS));

  ctl_t                 ctl_w [ITERATIONS+1];
  logic signed [WD-1:0] x_w   [ITERATIONS+1];
  logic signed [WD-1:0] y_w   [ITERATIONS+1];
  logic signed [WD-1:0] z_w   [ITERATIONS+1];

  logic                 vld_r;
  logic [E_W-1:0]       exp_r, exp_nxt;
  ctl_t                 fin;
  logic signed [WD:0]   sum;
  logic signed [WD:0]   scaled;
  logic signed [WD:0]   res;
  logic signed [4:0]    kneg;
  logic [3:0]           sh;

  assign busy = 1'b0;

  ehc_reduce #(
    .FRAC_BITS (INTERNAL_FRAC_BITS)
  ) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_x    (in_x_value),
    .out_ctl (ctl_w[0]),
    .out_r   (z_w[0])
  );

  assign x_w[0] = signed'(INVK);
  assign y_w[0] = '0;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    localparam int unsigned S = shift_of(i);
    localparam logic [WD-1:0] A = WD'(floor_f(atanh_hiq(S), INTERNAL_FRAC_BITS));
    ehc_rot #(
      .WD    (WD),
      .SHIFT (S),
      .ATANH (A)
    ) u_rot (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (ctl_w[i]),
      .in_x    (x_w[i]),
      .in_y    (y_w[i]),
      .in_z    (z_w[i]),
      .out_ctl (ctl_w[i+1]),
      .out_x   (x_w[i+1]),
      .out_y   (y_w[i+1]),
      .out_z   (z_w[i+1])
    );
  end

  // output: (X + Y) >> -k, back to 16 fraction bits
  always_comb begin
    fin    = ctl_w[ITERATIONS];
    sum    = {x_w[ITERATIONS][WD-1], x_w[ITERATIONS]} + {y_w[ITERATIONS][WD-1], y_w[ITERATIONS]};
    kneg   = -fin.k;
    sh     = '0;
    if (fin.k <= 5'sd0 && fin.k >= -5'sd12) begin
      sh = kneg[3:0];
    end
    scaled  = sum >>> sh;
    res     = scaled >>> OSH;
    exp_nxt = fin.zero ? '0 : res[E_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
  end

  assign out_valid     = vld_r;
  assign out_exp_value = exp_r;

endmodule

>>> design/ehc_reduce.sv
// Range reduction: x = k*ln2 + r, three register stages.
module ehc_reduce import ehc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [X_W-1:0]              in_x,
  output ctl_t                               out_ctl,
  output logic signed [FRAC_BITS+INT_BITS-1:0] out_r
);

  localparam int unsigned WD = FRAC_BITS + INT_BITS;
  localparam int unsigned SH = FRAC_BITS - IO_FRAC;
  localparam logic [WD-1:0] LN2F = WD'(floor_f(ln2_hiq(), FRAC_BITS));

  logic signed [WD-1:0] mult_w [K_SPAN+1];
  logic [THR_N:1]       thr_hit;

  logic signed [X_W-1:0] xc;
  logic signed [WD-1:0]  xi;
  logic                  below;
  logic [3:0]            kmag;

  ctl_t                  a_ctl_r, a_ctl_nxt;
  logic signed [WD-1:0]  a_xi_r;
  ctl_t                  b_ctl_r;
  logic signed [WD-1:0]  b_r_r, b_r_nxt;
  ctl_t                  c_ctl_r, c_ctl_nxt;
  logic signed [WD-1:0]  c_r_r, c_r_nxt;
  logic signed [4:0]     a_kneg;

  for (genvar j = 0; j <= K_SPAN; j++) begin : g_mult
    localparam logic [63:0] FV = floor_f(ln2_hiq() * 64'(j), FRAC_BITS);
    assign mult_w[j] = WD'(FV);
  end

  for (genvar j = 1; j <= THR_N; j++) begin : g_thr
    localparam logic [63:0] CV = ceil_f(ln2_hiq() * 64'(j), FRAC_BITS);
    localparam logic signed [WD-1:0] THR = WD'(64'd0 - CV);
    assign thr_hit[j] = (xi >= THR);
  end

  // stage A: clamp, scale, pick k
  always_comb begin
    below = (in_x < X_LOW);
    xc    = (in_x > 0) ? '0 : in_x;
    xi    = signed'({{(WD-X_W){xc[X_W-1]}}, xc}) <<< SH;
    kmag  = 4'(K_SPAN);
    for (int j = THR_N; j >= 1; j--) begin
      if (thr_hit[j]) kmag = 4'(j);
    end
    if (xi >= 0) kmag = '0;
    a_ctl_nxt.vld  = in_vld;
    a_ctl_nxt.zero = below;
    a_ctl_nxt.k    = -signed'({1'b0, kmag});
  end

  // stage B: r = x + |k|*ln2
  always_comb begin
    a_kneg  = -a_ctl_r.k;
    b_r_nxt = a_xi_r + mult_w[a_kneg[3:0]];
  end

  // stage C: one correction step into [0, ln2)
  always_comb begin
    c_ctl_nxt = b_ctl_r;
    c_r_nxt   = b_r_r;
    if (b_r_r < 0) begin
      c_r_nxt     = b_r_r + signed'(LN2F);
      c_ctl_nxt.k = b_ctl_r.k - 5'sd1;
    end else if (b_r_r >= signed'(LN2F)) begin
      c_r_nxt     = b_r_r - signed'(LN2F);
      c_ctl_nxt.k = b_ctl_r.k + 5'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
    end else begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= a_ctl_r;
      c_ctl_r <= c_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_xi_r <= xi;
    b_r_r  <= b_r_nxt;
    c_r_r  <= c_r_nxt;
  end

  assign out_ctl = c_ctl_r;
  assign out_r   = c_r_r;

endmodule

>>> design/ehc_rot.sv
// One registered hyperbolic CORDIC rotation stage.
module ehc_rot import ehc_pkg::*; #(
  parameter int unsigned WD    = FRAC_BITS_DEF + INT_BITS,
  parameter int unsigned SHIFT = 1,
  parameter logic [WD-1:0] ATANH = '0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 in_ctl,
  input  logic signed [WD-1:0] in_x,
  input  logic signed [WD-1:0] in_y,
  input  logic signed [WD-1:0] in_z,
  output ctl_t                 out_ctl,
  output logic signed [WD-1:0] out_x,
  output logic signed [WD-1:0] out_y,
  output logic signed [WD-1:0] out_z
);

  ctl_t                 ctl_r;
  logic signed [WD-1:0] x_r, x_nxt;
  logic signed [WD-1:0] y_r, y_nxt;
  logic signed [WD-1:0] z_r, z_nxt;
  logic signed [WD-1:0] xs, ys;

  always_comb begin
    xs = in_x >>> SHIFT;
    ys = in_y >>> SHIFT;
    if (!in_z[WD-1]) begin
      x_nxt = in_x + ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - signed'(ATANH);
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + signed'(ATANH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign out_ctl = ctl_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;

endmodule
